// ----- rtl/core/hlms_pkg.sv -----
// ----------------------------------------------------------------------------
// hlms_pkg
// Shared types, sizes and the hash fold step for the location mark set.
// ----------------------------------------------------------------------------
package hlms_pkg;

	// Table size and derived widths
	localparam int CAPACITY = 1024;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int HASH_W   = 31;

	// Hash constants
	localparam logic [31:0]       HASH_MUL = 32'd16807;
	localparam logic [HASH_W-1:0] HASH_MOD = 31'h7fffffff;

	// Request mode codes
	localparam logic MODE_QUERY = 1'b0;
	localparam logic MODE_MARK  = 1'b1;

	// Job passed from front to back
	typedef struct packed {
		logic              mode;
		logic [HASH_W-1:0] hash;
	} hlms_job_t;

	// Result beat, found in the lowest bit
	typedef struct packed {
		logic [HASH_W-1:0] location_hash;
		logic              table_full;
		logic              added;
		logic              found;
	} hlms_result_t;

	// One fold: (x * 16807 mod 2^32) mod (2^31 - 1).
	// 2^31 is 1 modulo the prime, so the top bit folds back in as +1,
	// leaving at most one subtraction.
	function automatic logic [HASH_W-1:0] fold_word(input logic [31:0] x);
		logic [31:0] p;
		logic [31:0] r;
		p = x * HASH_MUL;
		r = {1'b0, p[30:0]} + {31'd0, p[31]};
		if (r >= {1'b0, HASH_MOD}) begin
			r = r - {1'b0, HASH_MOD};
		end
		return r[HASH_W-1:0];
	endfunction

endpackage

// ----- rtl/core/hlms_front.sv -----
// ----------------------------------------------------------------------------
// hlms_front
// Accepts character beats, keeps the running hash and folds in the line
// number on the last beat, then hands a lookup job to the queue.
// ----------------------------------------------------------------------------
module hlms_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_mode,
	input  logic [7:0]          in_char,
	input  logic                in_char_valid,
	input  logic                in_last,
	input  logic [30:0]         in_line,
	output logic                job_valid,
	input  logic                job_ready,
	output hlms_pkg::hlms_job_t job
);
	import hlms_pkg::*;

	localparam logic ST_ACCEPT = 1'b0;
	localparam logic ST_LINE   = 1'b1;

	logic              state_q;
	logic [HASH_W-1:0] hash_q;
	logic [30:0]       line_q;
	logic              mode_q;
	logic              accept;
	logic [31:0]       char_x;
	logic [HASH_W-1:0] line_hash;

	assign in_ready = (state_q == ST_ACCEPT);
	assign accept   = in_valid && in_ready;

	// Sign-extended character mixed into the running hash
	assign char_x    = {{24{in_char[7]}}, in_char} ^ {1'b0, hash_q};
	assign line_hash = fold_word({1'b0, hash_q ^ line_q});

	assign job_valid = (state_q == ST_LINE);
	assign job.mode  = mode_q;
	assign job.hash  = line_hash;

	// Running hash and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCEPT;
			hash_q  <= '0;
		end else begin
			case (state_q)
				ST_ACCEPT: begin
					if (accept) begin
						if (in_char_valid) begin
							hash_q <= fold_word(char_x);
						end
						if (in_last) begin
							state_q <= ST_LINE;
						end
					end
				end
				ST_LINE: begin
					if (job_ready) begin
						hash_q  <= '0;
						state_q <= ST_ACCEPT;
					end
				end
				default: state_q <= ST_ACCEPT;
			endcase
		end
	end

	// Last-beat payload
	always_ff @(posedge clk) begin
		if (accept && in_last) begin
			line_q <= in_line;
			mode_q <= in_mode;
		end
	end

endmodule

// ----- rtl/core/hlms_queue.sv -----
// ----------------------------------------------------------------------------
// hlms_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module hlms_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  hlms_pkg::hlms_job_t push_job,
	output logic                pop_valid,
	input  logic                pop_ready,
	output hlms_pkg::hlms_job_t pop_job
);
	import hlms_pkg::*;

	hlms_job_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_job    = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ----- rtl/core/hlms_back.sv -----
// ----------------------------------------------------------------------------
// hlms_back
// Walks the stored hashes one per cycle, adds marks and drives the result
// register.
// ----------------------------------------------------------------------------
module hlms_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	output logic                 job_ready,
	input  hlms_pkg::hlms_job_t  job,
	output logic                 res_valid,
	input  logic                 res_ready,
	output hlms_pkg::hlms_result_t res
);
	import hlms_pkg::*;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_SCAN = 2'd1;
	localparam logic [1:0] B_DONE = 2'd2;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic              pend_q;
	logic              found_q;
	logic              mode_q;
	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] rd_s1;
	logic              out_valid_q;
	hlms_result_t      out_q;
	logic [HASH_W-1:0] mem [CAPACITY];
	logic              issue;
	logic              full;
	logic              finish;
	logic              add;
	logic              wr_en;

	assign full      = (count_q == CNT_W'(CAPACITY));
	assign issue     = (state_q == B_SCAN) && (idx_q < count_q);
	assign finish    = (state_q == B_DONE) && (!out_valid_q || res_ready);
	assign add       = (mode_q == MODE_MARK) && !found_q && !full;
	assign wr_en     = finish && add;
	assign job_ready = (state_q == B_IDLE);
	assign res_valid = out_valid_q;
	assign res       = out_q;

	// Lookup sequencer and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result valid: set on finish, cleared once taken
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						idx_q   <= '0;
						pend_q  <= 1'b0;
						found_q <= 1'b0;
						state_q <= B_SCAN;
					end
				end
				B_SCAN: begin
					pend_q <= issue;
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					// read data of the previous cycle compared here
					if (pend_q && (rd_s1 == hash_q)) begin
						found_q <= 1'b1;
						state_q <= B_DONE;
					end else if (!issue && !pend_q) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (finish) begin
						if (add) begin
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Job payload and result register
	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			mode_q <= job.mode;
			hash_q <= job.hash;
		end
		if (finish) begin
			out_q.found         <= found_q;
			out_q.added         <= add;
			out_q.table_full    <= full;
			out_q.location_hash <= hash_q;
		end
	end

	// Hash table: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[ADDR_W-1:0]] <= hash_q;
		end
		if (issue) begin
			rd_s1 <= mem[idx_q[ADDR_W-1:0]];
		end
	end

endmodule

// ----- rtl/core/hashed_location_mark_set_core.sv -----
// ----------------------------------------------------------------------------
// hashed_location_mark_set_core: a last beat holds off the input until its job
// enters the queue. Lookup reads the stored entries in turn (one table read per
// cycle) and stops at a match. arst_n clears hash, count and queue; table
// contents are undefined and only entries below count are read.
// ----------------------------------------------------------------------------
module hashed_location_mark_set_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // name_char[7:0], char_valid[8], line_number[39:9]
	input  logic        s_axis_tlast,
	input  logic        s_axis_tuser,  // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // found, added, table_full, location_hash[33:3]
);
	import hlms_pkg::*;

	logic         push_valid;
	logic         push_ready;
	hlms_job_t    push_job;
	logic         pop_valid;
	logic         pop_ready;
	hlms_job_t    pop_job;
	hlms_result_t res;

	hlms_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_mode       (s_axis_tuser),
		.in_char       (s_axis_tdata[7:0]),
		.in_char_valid (s_axis_tdata[8]),
		.in_last       (s_axis_tlast),
		.in_line       (s_axis_tdata[39:9]),
		.job_valid     (push_valid),
		.job_ready     (push_ready),
		.job           (push_job)
	);

	hlms_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	hlms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job_ready (pop_ready),
		.job       (pop_job),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {6'd0, res};

`ifndef SYNTHESIS
	// a pushed job is visible to the back on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && push_ready) |=> pop_valid)
		else $error("queue lost a pushed job");

	// final hash is fully reduced
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res.location_hash != HASH_MOD))
		else $error("location hash not reduced");

	// a new entry only when absent and room is left
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res.added) |-> (!res.found && !res.table_full))
		else $error("added with found or full");
`endif

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: hashed_location_mark_set_core
// Streams names with line numbers through the core: a short table of corner
// beats, then random well-formed names with old locations repeated, pausing
// once midway until every result is back. Each result beat is checked field
// by field against a local hash and membership tracker.
// ----------------------------------------------------------------------------
module tb;
	import hlms_pkg::*;

	localparam int      N_DIRECTED     = 24;
	localparam int      N_ITEMS        = 580;
	localparam int      HOLD_OFF       = 500;
	localparam int      LOOKUP_DRAIN   = CAPACITY + 16;
	localparam int      WATCHDOG_LIMIT = 12000;
	localparam longint  FOLD_MUL       = 64'd16807;
	localparam longint  FOLD_PRIME     = 64'h7fff_ffff;

	// One row of the directed table; want is used only when typed is set
	typedef struct packed {
		logic         md;
		logic [7:0]   ch;
		logic         cv;
		logic         lst;
		logic [30:0]  ln;
		logic         typed;
		hlms_result_t want;
	} row_t;

	// A location: name characters plus line number
	typedef struct {
		logic [7:0]  nm [8];
		int          len;
		logic [30:0] ln;
	} loc_t;

	localparam hlms_result_t NO_WANT = '0;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata  = '0;
	logic        s_axis_tlast  = 1'b0;
	logic        s_axis_tuser  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;

	// Tracker state
	logic [30:0]  name_hash = '0;
	int           n_stored  = 0;
	bit           stored_set [logic [30:0]];
	hlms_result_t lookup_answers [$];
	loc_t         seen_locs [$];

	int errors       = 0;
	int n_items      = 0;
	int results_seen = 0;
	int n_found      = 0;
	int n_added      = 0;
	int n_full_res   = 0;
	bit quiet_tx     = 1'b0;
	bit quiet_rx     = 1'b0;

	// Directed beats: typed = want hash/flags, read off directly
	// want fields: location_hash, table_full, added, found
	row_t dir_rows [N_DIRECTED] = '{
		// empty names right after reset
		'{MODE_QUERY, 8'h00, 1'b0, 1'b1, 31'd0, 1'b1, '{31'd0, 1'b0, 1'b0, 1'b0}},
		'{MODE_QUERY, 8'h00, 1'b0, 1'b1, 31'd1, 1'b1, '{31'd16807, 1'b0, 1'b0, 1'b0}},
		'{MODE_MARK,  8'h00, 1'b0, 1'b1, 31'd1, 1'b1, '{31'd16807, 1'b0, 1'b1, 1'b0}},
		'{MODE_MARK,  8'h00, 1'b0, 1'b1, 31'd1, 1'b1, '{31'd16807, 1'b0, 1'b0, 1'b1}},
		'{MODE_QUERY, 8'h00, 1'b0, 1'b1, 31'd1, 1'b1, '{31'd16807, 1'b0, 1'b0, 1'b1}},
		// character extremes, last char rides on the last beat, mark
		'{MODE_MARK,  8'h61, 1'b1, 1'b0, 31'd0,         1'b0, NO_WANT},
		'{MODE_QUERY, 8'h80, 1'b1, 1'b0, 31'h7fff_ffff, 1'b0, NO_WANT},
		'{MODE_MARK,  8'h7f, 1'b1, 1'b0, 31'd0,         1'b0, NO_WANT},
		'{MODE_QUERY, 8'hff, 1'b0, 1'b0, 31'h5555_5555, 1'b0, NO_WANT},
		'{MODE_MARK,  8'hff, 1'b1, 1'b1, 31'h7fff_ffff, 1'b0, NO_WANT},
		// same name, query
		'{MODE_MARK,  8'h61, 1'b1, 1'b0, 31'd0,         1'b0, NO_WANT},
		'{MODE_MARK,  8'h80, 1'b1, 1'b0, 31'd0,         1'b0, NO_WANT},
		'{MODE_QUERY, 8'h7f, 1'b1, 1'b0, 31'd0,         1'b0, NO_WANT},
		'{MODE_QUERY, 8'hff, 1'b1, 1'b1, 31'h7fff_ffff, 1'b0, NO_WANT},
		// same name split off the last beat, mark when already present
		'{MODE_QUERY, 8'h61, 1'b1, 1'b0, 31'd0,         1'b0, NO_WANT},
		'{MODE_QUERY, 8'h80, 1'b1, 1'b0, 31'd0,         1'b0, NO_WANT},
		'{MODE_QUERY, 8'h7f, 1'b1, 1'b0, 31'd0,         1'b0, NO_WANT},
		'{MODE_MARK,  8'hff, 1'b1, 1'b0, 31'd0,         1'b0, NO_WANT},
		'{MODE_MARK,  8'h00, 1'b0, 1'b1, 31'h7fff_ffff, 1'b0, NO_WANT},
		// zero character, zero line: hash stays zero
		'{MODE_QUERY, 8'h00, 1'b1, 1'b1, 31'd0, 1'b1, '{31'd0, 1'b0, 1'b0, 1'b0}},
		'{MODE_MARK,  8'h00, 1'b1, 1'b1, 31'd0, 1'b1, '{31'd0, 1'b0, 1'b1, 1'b0}},
		'{MODE_QUERY, 8'h00, 1'b0, 1'b1, 31'd0, 1'b1, '{31'd0, 1'b0, 1'b0, 1'b1}},
		'{MODE_MARK,  8'h55, 1'b1, 1'b1, 31'h4000_0000, 1'b0, NO_WANT},
		'{MODE_QUERY, 8'haa, 1'b1, 1'b1, 31'h2aaa_aaaa, 1'b0, NO_WANT}
	};

	hashed_location_mark_set_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// One hash step: ((h ^ c) * 16807 mod 2^32) mod (2^31 - 1)
	function automatic logic [30:0] fold_step(input logic [31:0] h, input logic [31:0] c);
		longint unsigned prod;
		prod = longint'(h ^ c) * FOLD_MUL;
		prod = prod & 64'hffff_ffff;
		return 31'(prod % FOLD_PRIME);
	endfunction

	// Advance the name hash; on a last beat, look up and maybe store
	task automatic hash_and_lookup(input logic md, input logic [7:0] ch, input logic cv,
			input logic lst, input logic [30:0] ln, output logic has, output hlms_result_t r);
		logic [30:0] h;
		has = 1'b0;
		r   = '0;
		if (cv) begin
			name_hash = fold_step({1'b0, name_hash}, {{24{ch[7]}}, ch});
		end
		if (lst) begin
			h = fold_step({1'b0, name_hash}, {1'b0, ln});
			name_hash = '0;
			r.location_hash = h;
			r.found         = stored_set.exists(h);
			r.table_full    = (n_stored >= CAPACITY);
			r.added         = (md == MODE_MARK) && !r.found && !r.table_full;
			if (r.added) begin
				stored_set[h] = 1'b1;
				n_stored++;
			end
			has = 1'b1;
		end
	endtask

	// Mostly short gaps, now and then a long one; none in quiet stretches
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_tx || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [30:0] rand_line();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) return 31'($urandom_range(0, 15));
		if (r == 4) return 31'h7fff_ffff;
		if (r == 5) return 31'd0;
		return 31'($urandom);
	endfunction

	function automatic loc_t make_loc(input int max_len);
		loc_t l;
		l.len = $urandom_range(0, max_len);
		for (int k = 0; k < 8; k++) begin
			l.nm[k] = 8'($urandom_range(0, 255));
		end
		l.ln = rand_line();
		return l;
	endfunction

	// Drive one beat, wait for the handshake, then track it
	task automatic send_beat(input logic md, input logic [7:0] ch, input logic cv,
			input logic lst, input logic [30:0] ln, input logic typed, input hlms_result_t want);
		int           gap;
		logic         has;
		hlms_result_t pred;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {ln, cv, ch};
		s_axis_tlast  <= lst;
		s_axis_tuser  <= md;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		hash_and_lookup(md, ch, cv, lst, ln, has, pred);
		if (has) lookup_answers.push_back(typed ? want : pred);
		n_items++;
	endtask

	// A name as character beats, the last char sometimes on the last beat
	task automatic send_loc(input loc_t l, input logic md);
		int tail;
		if ($urandom_range(0, 7) == 0) begin
			// ignored beat: no character, not last
			send_beat(1'($urandom), 8'($urandom), 1'b0, 1'b0, 31'($urandom), 1'b0, NO_WANT);
		end
		tail = (l.len > 0) ? $urandom_range(0, 1) : 0;
		for (int k = 0; k < l.len - tail; k++) begin
			send_beat(1'($urandom), l.nm[k], 1'b1, 1'b0, 31'($urandom), 1'b0, NO_WANT);
		end
		send_beat(md, (tail != 0) ? l.nm[l.len-1] : 8'($urandom), tail[0], 1'b1, l.ln,
			1'b0, NO_WANT);
	endtask

	task automatic drain_answers();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (lookup_answers.size() != 0);
	endtask

	task automatic check_field(input string nm, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, want, got);
		end
	endtask

	// Stimulus
	initial begin
		loc_t l;
		int   n_locs;
		bit   mid_drained;
		mid_drained = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_beat(dir_rows[i].md, dir_rows[i].ch, dir_rows[i].cv, dir_rows[i].lst,
				dir_rows[i].ln, dir_rows[i].typed, dir_rows[i].want);
		end

		// Random names, a third of them repeats of earlier locations
		n_locs = 0;
		while (n_items < N_ITEMS) begin
			// once midway, let every outstanding result come back
			if (!mid_drained && n_items >= N_ITEMS / 2) begin
				mid_drained = 1'b1;
				drain_answers();
			end
			if (n_locs % 16 == 0) quiet_tx = ($urandom_range(0, 3) == 0);
			n_locs++;
			if (seen_locs.size() > 0 && $urandom_range(0, 99) < 35) begin
				l = seen_locs[$urandom_range(0, seen_locs.size() - 1)];
			end else begin
				l = make_loc(8);
				seen_locs.push_back(l);
			end
			send_loc(l, 1'($urandom));
		end
		drain_answers();
		repeat (LOOKUP_DRAIN) @(posedge clk);

		$display("Sent %0d beats; got %0d results (%0d found, %0d added, %0d with table full).",
			n_items, results_seen, n_found, n_added, n_full_res);
		$display("Table ended with %0d of %0d entries; %0d mismatches.", n_stored, CAPACITY, errors);
		if (errors == 0) begin
			$display("** hashed_location_mark_set_core: PASSED **");
		end else begin
			$display("** hashed_location_mark_set_core: FAILED **");
		end
		$finish;
	end

	// Result side ready: random stalls, quiet stretches, one long hold-off
	initial begin
		int stall;
		int cyc;
		bit held;
		stall = 0;
		cyc   = 0;
		held  = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 256 == 0) quiet_rx = ($urandom_range(0, 2) == 0);
			if (!held && results_seen >= 40) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end else if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else if (quiet_rx || $urandom_range(0, 99) < 70) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b0;
				stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
			end
		end
	end

	// Check each result beat against the oldest answer
	always @(posedge clk) begin
		hlms_result_t got;
		hlms_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = hlms_result_t'(m_axis_tdata[33:0]);
			results_seen++;
			n_found    += int'(got.found);
			n_added    += int'(got.added);
			n_full_res += int'(got.table_full);
			if (lookup_answers.size() == 0) begin
				errors++;
				$display("%0t: result beat with none expected, actual %0h", $time, m_axis_tdata);
			end else begin
				want = lookup_answers.pop_front();
				check_field("found", 32'(want.found), 32'(got.found));
				check_field("added", 32'(want.added), 32'(got.added));
				check_field("table_full", 32'(want.table_full), 32'(got.table_full));
				check_field("location_hash", 32'(want.location_hash),
					32'(got.location_hash));
				check_field("tdata padding", 32'd0, 32'(m_axis_tdata[39:34]));
			end
		end
	end

	// Watchdog: cycles with no beat moving on either side
	initial begin
		int idle;
		idle = 0;
		wait (arst_n);
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("%0t: watchdog, no beat moved for %0d cycles, %0d results outstanding",
			$time, idle, lookup_answers.size());
		$display("** hashed_location_mark_set_core: FAILED **");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/hlms_pkg.sv
rtl/core/hlms_front.sv
rtl/core/hlms_queue.sv
rtl/core/hlms_back.sv
rtl/core/hashed_location_mark_set_core.sv
tb/sv/tb.sv
